### src/rtsp_pkg.sv
// Shared types, constants and control program of the touch sample processor.
// No dependencies; every other file imports this package.
package rtsp_pkg;

    // Sample and arithmetic constants
    localparam logic [11:0] MAX_SAMPLE  = 12'd4095;
    localparam logic [40:0] PLATE_OHMS  = 41'd400;
    localparam logic [32:0] ROUND_ADD   = 33'd2047;
    localparam logic [12:0] RAW_MAX_RST = 13'd4096;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_X_MIN  = 3'd0;
    localparam logic [2:0] REG_X_MAX  = 3'd1;
    localparam logic [2:0] REG_Y_MIN  = 3'd2;
    localparam logic [2:0] REG_Y_MAX  = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;

    // Input word, one poll
    typedef struct packed {
        logic        pen_pin;
        logic [11:0] x_sample;
        logic [11:0] y_sample;
        logic [11:0] z1_sample;
        logic [11:0] z2_sample;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic        key_valid;
        logic        key_pressed;
        logic        pos_valid;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [11:0] pressure;
        logic        pressure_over;
        logic        poll_again;
    } out_word_t;

    // Calibration registers
    typedef struct packed {
        logic [11:0] x_lo;
        logic [12:0] x_hi;
        logic [11:0] y_lo;
        logic [12:0] y_hi;
        logic [11:0] disp_w;
        logic [11:0] disp_h;
    } cfg_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL_DX,
        OP_MUL_400,
        OP_DIV_P,
        OP_ROUND,
        OP_MUL_X,
        OP_MUL_Y,
        OP_DIV_S,
        OP_POS_X,
        OP_POS_Y,
        OP_FIN
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NONE,
        C_NO_START,
        C_REL_PIN,
        C_P_SKIP,
        C_DIV_BUSY,
        C_SKIP_POS,
        C_OUT_BLOCKED
    } cond_t;

    typedef logic [4:0] step_t;

    localparam step_t STEP_IDLE = 5'd0;
    localparam step_t STEP_WAITP = 5'd5;
    localparam step_t STEP_WAITX = 5'd10;
    localparam step_t STEP_WAITY = 5'd14;
    localparam step_t STEP_FIN  = 5'd16;

    // One control word per step; ret sends fall-through back to idle
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  ret;
    } ctrl_word_t;

    // Status from datapath to sequencer
    typedef struct packed {
        logic rel_pin;
        logic p_skip;
        logic div_busy;
        logic skip_pos;
        logic out_blocked;
    } stat_t;

    // Control program
    function automatic ctrl_word_t prog_rom(input step_t s);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: C_NONE, target: STEP_IDLE, ret: 1'b0};
        case (s)
            5'd0:  w = '{op: OP_NOP,     cond: C_NO_START,    target: STEP_IDLE,  ret: 1'b0};
            5'd1:  w = '{op: OP_NOP,     cond: C_REL_PIN,     target: STEP_FIN,   ret: 1'b0};
            5'd2:  w = '{op: OP_MUL_DX,  cond: C_P_SKIP,      target: STEP_FIN,   ret: 1'b0};
            5'd3:  w = '{op: OP_MUL_400, cond: C_NONE,        target: STEP_IDLE,  ret: 1'b0};
            5'd4:  w = '{op: OP_DIV_P,   cond: C_NONE,        target: STEP_IDLE,  ret: 1'b0};
            5'd5:  w = '{op: OP_NOP,     cond: C_DIV_BUSY,    target: STEP_WAITP, ret: 1'b0};
            5'd6:  w = '{op: OP_ROUND,   cond: C_NONE,        target: STEP_IDLE,  ret: 1'b0};
            5'd7:  w = '{op: OP_NOP,     cond: C_SKIP_POS,    target: STEP_FIN,   ret: 1'b0};
            5'd8:  w = '{op: OP_MUL_X,   cond: C_NONE,        target: STEP_IDLE,  ret: 1'b0};
            5'd9:  w = '{op: OP_DIV_S,   cond: C_NONE,        target: STEP_IDLE,  ret: 1'b0};
            5'd10: w = '{op: OP_NOP,     cond: C_DIV_BUSY,    target: STEP_WAITX, ret: 1'b0};
            5'd11: w = '{op: OP_POS_X,   cond: C_NONE,        target: STEP_IDLE,  ret: 1'b0};
            5'd12: w = '{op: OP_MUL_Y,   cond: C_NONE,        target: STEP_IDLE,  ret: 1'b0};
            5'd13: w = '{op: OP_DIV_S,   cond: C_NONE,        target: STEP_IDLE,  ret: 1'b0};
            5'd14: w = '{op: OP_NOP,     cond: C_DIV_BUSY,    target: STEP_WAITY, ret: 1'b0};
            5'd15: w = '{op: OP_POS_Y,   cond: C_NONE,        target: STEP_IDLE,  ret: 1'b0};
            5'd16: w = '{op: OP_FIN,     cond: C_OUT_BLOCKED, target: STEP_FIN,   ret: 1'b1};
            default: w = '{op: OP_NOP,   cond: C_NONE,        target: STEP_IDLE,  ret: 1'b1};
        endcase
        return w;
    endfunction

endpackage

### src/rtsp_cfg.sv
// Calibration register file behind the APB-style configuration port.
// Depends on rtsp_pkg for cfg_t and the register indexes.
module rtsp_cfg
    import rtsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx   = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_X_MIN:  cfg_next.x_lo   = pwdata[11:0];
                REG_X_MAX:  cfg_next.x_hi   = pwdata[12:0];
                REG_Y_MIN:  cfg_next.y_lo   = pwdata[11:0];
                REG_Y_MAX:  cfg_next.y_hi   = pwdata[12:0];
                REG_WIDTH:  cfg_next.disp_w = pwdata[11:0];
                REG_HEIGHT: cfg_next.disp_h = pwdata[11:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_lo   <= '0;
            cfg_reg.x_hi   <= RAW_MAX_RST;
            cfg_reg.y_lo   <= '0;
            cfg_reg.y_hi   <= RAW_MAX_RST;
            cfg_reg.disp_w <= '0;
            cfg_reg.disp_h <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_X_MIN:  prdata = {20'd0, cfg_reg.x_lo};
            REG_X_MAX:  prdata = {19'd0, cfg_reg.x_hi};
            REG_Y_MIN:  prdata = {20'd0, cfg_reg.y_lo};
            REG_Y_MAX:  prdata = {19'd0, cfg_reg.y_hi};
            REG_WIDTH:  prdata = {20'd0, cfg_reg.disp_w};
            REG_HEIGHT: prdata = {20'd0, cfg_reg.disp_h};
            default:    prdata = '0;
        endcase
    end

endmodule

### src/rtsp_div.sv
// Shared unsigned divider, 32-bit dividend by 13-bit divisor, two bits per cycle.
// Depends on rtsp_pkg (imported for house consistency of types).
module rtsp_div
    import rtsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [12:0] den,
    output logic        busy,
    output logic [31:0] quo
);

    logic        busy_reg;
    logic        busy_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic [12:0] rem_reg;
    logic [12:0] rem_next;
    logic [31:0] quo_reg;
    logic [31:0] quo_next;
    logic [12:0] den_reg;
    logic [12:0] den_next;
    logic [13:0] t1;
    logic [13:0] r1;
    logic [13:0] t2;
    logic [13:0] r2;
    logic        ge1;
    logic        ge2;

    // Two restoring steps per cycle
    always_comb
    begin
        t1  = {rem_reg, quo_reg[31]};
        ge1 = t1 >= {1'b0, den_reg};
        r1  = ge1 ? (t1 - {1'b0, den_reg}) : t1;
        t2  = {r1[12:0], quo_reg[30]};
        ge2 = t2 >= {1'b0, den_reg};
        r2  = ge2 ? (t2 - {1'b0, den_reg}) : t2;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = r2[12:0];
            quo_next = {quo_reg[29:0], ge1, ge2};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

### src/rtsp_seq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
// Depends on rtsp_pkg for the program, control word and status types.
module rtsp_seq
    import rtsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  stat_t      stat,
    output ctrl_word_t ctrl,
    output logic       idle
);

    step_t pc_reg;
    step_t pc_next;
    logic  jump;

    assign ctrl = prog_rom(pc_reg);
    assign idle = (pc_reg == STEP_IDLE);

    // Jump condition select
    always_comb
    begin
        case (ctrl.cond)
            C_NONE:        jump = 1'b0;
            C_NO_START:    jump = !in_valid;
            C_REL_PIN:     jump = stat.rel_pin;
            C_P_SKIP:      jump = stat.p_skip;
            C_DIV_BUSY:    jump = stat.div_busy;
            C_SKIP_POS:    jump = stat.skip_pos;
            C_OUT_BLOCKED: jump = stat.out_blocked;
            default:       jump = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        if (jump)
        begin
            pc_next = ctrl.target;
        end
        else if (ctrl.ret)
        begin
            pc_next = STEP_IDLE;
        end
        else
        begin
            pc_next = pc_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

### src/rtsp_dp.sv
// Datapath: input word, multiplier stages, shared divider, result register.
// Depends on rtsp_pkg and instantiates rtsp_div.
module rtsp_dp
    import rtsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_word_t ctrl,
    input  cfg_t       cfg,
    input  logic       in_accept,
    input  in_word_t   in_word,
    input  logic       out_ready,
    output logic       out_valid,
    output out_word_t  out_word,
    output stat_t      stat
);

    in_word_t    in_reg;
    logic [31:0] a_reg;
    logic [31:0] a_next;
    logic [19:0] p_reg;
    logic [19:0] p_next;
    logic        neg_reg;
    logic        neg_next;
    logic        spanz_reg;
    logic        spanz_next;
    logic [12:0] den_reg;
    logic [12:0] den_next;
    logic [11:0] posx_reg;
    logic [11:0] posx_next;
    logic [11:0] posy_reg;
    logic [11:0] posy_next;
    logic        pen_down_reg;
    logic        pen_down_next;
    out_word_t   out_reg;
    out_word_t   out_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [11:0] xp;
    logic [31:0] dz;
    logic [43:0] prod_dx;
    logic [40:0] prod_400;
    logic [32:0] sum_rnd;
    logic        axis_y;
    logic [11:0] raw;
    logic [11:0] lo;
    logic [12:0] hi;
    logic [11:0] size;
    logic [12:0] diff;
    logic [12:0] dmag_full;
    logic [23:0] prod_s;
    logic [13:0] span;
    logic [13:0] smag_full;
    logic [11:0] pos_res;
    logic        div_start;
    logic [12:0] div_den;
    logic        div_busy;
    logic [31:0] div_quo;
    logic        scale_on;
    logic        p_over;
    logic        p_zero;
    logic        rel_pin;
    logic        nz;
    logic        out_blocked;
    logic        fin_fire;

    // Pressure terms
    assign xp       = (in_reg.x_sample == MAX_SAMPLE) ? 12'd0 : in_reg.x_sample;
    assign dz       = {20'd0, in_reg.z2_sample} - {20'd0, in_reg.z1_sample};
    assign prod_dx  = {12'd0, dz} * {32'd0, xp};
    assign prod_400 = {9'd0, a_reg} * PLATE_OHMS;
    assign sum_rnd  = {1'b0, div_quo} + ROUND_ADD;

    // Axis operand select for scaling
    assign axis_y = (ctrl.op == OP_MUL_Y) || (ctrl.op == OP_POS_Y);
    assign raw    = axis_y ? in_reg.y_sample : in_reg.x_sample;
    assign lo     = axis_y ? cfg.y_lo : cfg.x_lo;
    assign hi     = axis_y ? cfg.y_hi : cfg.x_hi;
    assign size   = axis_y ? cfg.disp_h : cfg.disp_w;

    // Signed offset and span as sign and magnitude
    assign diff      = {1'b0, raw} - {1'b0, lo};
    assign dmag_full = diff[12] ? (13'd0 - diff) : diff;
    assign prod_s    = dmag_full[11:0] * size;
    assign span      = {1'b0, hi} - {2'b0, lo};
    assign smag_full = span[13] ? (14'd0 - span) : span;

    // Quotient back to a clamped coordinate
    always_comb
    begin
        if (spanz_reg || neg_reg)
        begin
            pos_res = '0;
        end
        else if (div_quo > {20'd0, size})
        begin
            pos_res = size;
        end
        else
        begin
            pos_res = div_quo[11:0];
        end
    end

    // Shared divider
    assign div_start = (ctrl.op == OP_DIV_P) || (ctrl.op == OP_DIV_S);
    assign div_den   = (ctrl.op == OP_DIV_P) ? {1'b0, in_reg.z1_sample} : den_reg;

    rtsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (a_reg),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // Status flags
    assign scale_on    = (cfg.disp_w != 12'd0) && (cfg.disp_h != 12'd0);
    assign p_over      = |p_reg[19:12];
    assign p_zero      = (p_reg == 20'd0);
    assign rel_pin     = pen_down_reg && !in_reg.pen_pin;
    assign nz          = !rel_pin && !p_over && !p_zero;
    assign out_blocked = out_valid_reg && !out_ready;
    assign fin_fire    = (ctrl.op == OP_FIN) && !out_blocked;

    assign stat.rel_pin     = rel_pin;
    assign stat.p_skip      = (xp == 12'd0) || (in_reg.z1_sample == 12'd0);
    assign stat.div_busy    = div_busy;
    assign stat.skip_pos    = p_over || p_zero || !scale_on;
    assign stat.out_blocked = out_blocked;

    // Operation decode
    always_comb
    begin
        a_next     = a_reg;
        p_next     = p_reg;
        neg_next   = neg_reg;
        spanz_next = spanz_reg;
        den_next   = den_reg;
        posx_next  = posx_reg;
        posy_next  = posy_reg;
        case (ctrl.op)
            OP_MUL_DX:
            begin
                a_next = prod_dx[31:0];
                p_next = '0;
            end
            OP_MUL_400:
            begin
                a_next = prod_400[31:0];
            end
            OP_ROUND:
            begin
                p_next = sum_rnd[31:12];
            end
            OP_MUL_X, OP_MUL_Y:
            begin
                a_next     = {8'd0, prod_s};
                neg_next   = diff[12] ^ span[13];
                spanz_next = (span == 14'd0);
                den_next   = smag_full[12:0];
            end
            OP_POS_X:
            begin
                posx_next = pos_res;
            end
            OP_POS_Y:
            begin
                posy_next = pos_res;
            end
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    // Result word and pen state
    always_comb
    begin
        out_next       = out_reg;
        pen_down_next  = pen_down_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (fin_fire)
        begin
            out_next.key_valid     = rel_pin || (nz && !pen_down_reg);
            out_next.key_pressed   = nz && !pen_down_reg;
            out_next.pos_valid     = nz;
            out_next.pos_x         = !nz ? 12'd0 : (scale_on ? posx_reg : in_reg.x_sample);
            out_next.pos_y         = !nz ? 12'd0 : (scale_on ? posy_reg : in_reg.y_sample);
            out_next.pressure      = nz ? p_reg[11:0] : 12'd0;
            out_next.pressure_over = !rel_pin && p_over;
            if (rel_pin)
            begin
                pen_down_next = 1'b0;
            end
            else if (nz)
            begin
                pen_down_next = 1'b1;
            end
            out_next.poll_again = pen_down_next;
            out_valid_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_down_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pen_down_reg  <= pen_down_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_reg <= in_word;
        end
        a_reg     <= a_next;
        p_reg     <= p_next;
        neg_reg   <= neg_next;
        spanz_reg <= spanz_next;
        den_reg   <= den_next;
        posx_reg  <= posx_next;
        posy_reg  <= posy_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

### src/resistive_touch_sample_processor.sv
// Touch sample processor: one poll word in, one result word out; one word in work at a time.
// A release by pin goes straight to the finish step, as does a poll with X at zero or full
// scale or Z1 at zero. Otherwise the pressure is computed and, unless it is over range or
// zero or scaling is off, each axis is scaled. Each divider run (pressure, then each axis)
// holds its wait step until the divider is done. The next word is taken the cycle after the
// result registers, which may wait on out_ready. Reset clears pen state, loads calibration.
module resistive_touch_sample_processor
    import rtsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_word
);

    cfg_t       cfg;
    ctrl_word_t ctrl;
    stat_t      stat;
    logic       idle;
    logic       in_accept;

    assign pready    = 1'b1;
    assign in_ready  = idle;
    assign in_accept = in_valid && in_ready;

    // Calibration registers
    rtsp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Program sequencer
    rtsp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctrl     (ctrl),
        .idle     (idle)
    );

    // Datapath
    rtsp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_word   (in_word),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_word  (out_word),
        .stat      (stat)
    );

`ifndef SYNTHESIS
    // No word is taken while the divider still runs
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !stat.div_busy)
        else $error("word accepted while divider busy");

    // A press leaves the pen down
    a_press_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.key_pressed) |-> (out_word.key_valid && out_word.poll_again))
        else $error("press without key or pen state");

    // An over-range pressure reports neither key nor position
    a_over_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.pressure_over) |->
            (!out_word.key_valid && !out_word.pos_valid && out_word.pressure == 12'd0))
        else $error("over-range word carries an event");

    // A release clears the pen state
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.key_valid && !out_word.key_pressed) |-> !out_word.poll_again)
        else $error("release left pen down");
`endif

endmodule
